// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 40;
    localparam int GAIN_W  = 32;
    localparam int DT_W    = 16;
    localparam int FRAC_W  = 16;
    localparam int CLAMP_W = 2;

    // Shared multiplier: 33x33 signed covers the error difference and zero-extended dt
    localparam int OPND_W  = DATA_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int ASUM_W  = TERM_W + 1;
    localparam int SUM_W   = TERM_W + 2;

    localparam int IN_TDATA_W  = 56;
    localparam int IN_USED_W   = DATA_W + DT_W + 1;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_USED_W  = DATA_W + CLAMP_W;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW   = 3'd5;

    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_CLEAR = 4'd7;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd8;

    typedef enum logic [1:0] {
        JMP_NONE    = 2'd0,
        JMP_CLEAR   = 2'd1,
        JMP_DT_ZERO = 2'd2,
        JMP_ALWAYS  = 2'd3
    } jmp_cond_t;

    typedef enum logic [1:0] {
        MA_ERR  = 2'd0,
        MA_INC  = 2'd1,
        MA_DIFF = 2'd2
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_DT = 2'd0,
        MB_KI = 2'd1,
        MB_KP = 2'd2,
        MB_KD = 2'd3
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_KEEP  = 2'd0,
        ACC_ADD   = 2'd1,
        ACC_CLAMP = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        SUM_KEEP     = 2'd0,
        SUM_LOAD     = 2'd1,
        SUM_ADD_PROD = 2'd2,
        SUM_ADD_ACC  = 2'd3
    } sum_op_t;

    typedef enum logic [1:0] {
        ST_KEEP   = 2'd0,
        ST_COMMIT = 2'd1,
        ST_CLEAR  = 2'd2
    } st_op_t;

    typedef struct packed {
        jmp_cond_t         jmp;
        logic [PC_W-1:0]   target;
        mul_a_t            mul_a;
        mul_b_t            mul_b;
        acc_op_t           acc_op;
        sum_op_t           sum_op;
        st_op_t            st_op;
        logic              emit;
    } ucode_t;

    typedef struct packed {
        logic   fire;
        ucode_t uc;
    } dp_ctrl_t;

    typedef struct packed {
        logic clear_op;
        logic dt_zero;
        logic out_busy;
    } dp_stat_t;

    // Control program. Multiplier result of each of steps 0 to 3 is consumed by the next one.
    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0: w = '{JMP_CLEAR,   PC_CLEAR, MA_ERR,  MB_DT, ACC_KEEP,  SUM_KEEP,
                        ST_KEEP,   1'b0};
            4'd1: w = '{JMP_DT_ZERO, PC_EMIT,  MA_INC,  MB_KI, ACC_KEEP,  SUM_KEEP,
                        ST_KEEP,   1'b0};
            4'd2: w = '{JMP_NONE,    PC_START, MA_ERR,  MB_KP, ACC_ADD,   SUM_KEEP,
                        ST_KEEP,   1'b0};
            4'd3: w = '{JMP_NONE,    PC_START, MA_DIFF, MB_KD, ACC_CLAMP, SUM_LOAD,
                        ST_KEEP,   1'b0};
            4'd4: w = '{JMP_NONE,    PC_START, MA_ERR,  MB_DT, ACC_KEEP,  SUM_ADD_PROD,
                        ST_KEEP,   1'b0};
            4'd5: w = '{JMP_NONE,    PC_START, MA_ERR,  MB_DT, ACC_KEEP,  SUM_ADD_ACC,
                        ST_KEEP,   1'b0};
            4'd6: w = '{JMP_ALWAYS,  PC_EMIT,  MA_ERR,  MB_DT, ACC_KEEP,  SUM_KEEP,
                        ST_COMMIT, 1'b0};
            4'd7: w = '{JMP_NONE,    PC_START, MA_ERR,  MB_DT, ACC_KEEP,  SUM_KEEP,
                        ST_CLEAR,  1'b0};
            4'd8: w = '{JMP_NONE,    PC_START, MA_ERR,  MB_DT, ACC_KEEP,  SUM_KEEP,
                        ST_KEEP,   1'b1};
            default: w = '{JMP_NONE, PC_START, MA_ERR,  MB_DT, ACC_KEEP,  SUM_KEEP,
                        ST_KEEP,   1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pid_controller_with_clamp.sv =====
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata (error_in, step_time, hold), s_tuser (operation)
// m_        out  m_tvalid/m_tready  m_tdata (drive_out, clamp_status)
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A control step runs through the microcode, one shared 33x33 multiplier
// pass per microcode step; a clear or a zero step time jumps past the gain steps.
// One request in flight; s_tready returns once its result is loaded into m_tdata,
// so the next request can enter while that result waits.
// The final step holds while m_tvalid is high and m_tready low.
// aresetn is synchronous, active low; gains, limits and loop state reset to zero.
module pid_controller_with_clamp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] error_in, [47:32] step_time, [48] hold, [55:49] zero
    input  logic [pidc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [0] operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] drive_out, [33:32] clamp_status, [39:34] zero
    output logic [pidc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidc_pkg::GAIN_W-1:0]       cfg_data
);
    import pidc_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     busy;
    logic     in_fire;
    logic     cfg_fire;

    assign s_tready  = !busy;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    pidc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    pidc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ctrl      (ctrl),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/pidc_seq.sv =====
module pidc_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  pidc_pkg::dp_stat_t stat,
    output pidc_pkg::dp_ctrl_t ctrl,
    output logic               busy
);
    import pidc_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uc;
    logic            fire;
    logic            take;

    assign uc   = ucode_rom(pc_reg);
    // the emit step waits while the previous result is still unread
    assign fire = busy_reg && !(uc.emit && stat.out_busy);

    always_comb begin
        case (uc.jmp)
            JMP_NONE:    take = 1'b0;
            JMP_CLEAR:   take = stat.clear_op;
            JMP_DT_ZERO: take = stat.dt_zero;
            JMP_ALWAYS:  take = 1'b1;
            default:     take = 1'b0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = PC_START;
        end else if (fire) begin
            if (uc.emit) begin
                busy_next = 1'b0;
                pc_next   = PC_START;
            end else if (take) begin
                pc_next = uc.target;
            end else begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_START;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign ctrl.fire = fire;
    assign ctrl.uc   = uc;
    assign busy      = busy_reg;

endmodule

// ===== rtl/pidc_dp.sv =====
module pidc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_fire,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidc_pkg::GAIN_W-1:0]       cfg_data,
    input  logic                              in_fire,
    input  logic [pidc_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,
    input  pidc_pkg::dp_ctrl_t                ctrl,
    output pidc_pkg::dp_stat_t                stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pidc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pidc_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg, lim_hi_reg, lim_lo_reg;
    logic                     ien_reg;

    // request fields
    logic                     op_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic [DT_W-1:0]          dt_reg;
    logic                     hold_reg;

    // loop state
    logic signed [DATA_W-1:0] last_err_reg, last_drive_reg, last_drive_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     first_reg;
    logic [CLAMP_W-1:0]       clamp_reg, clamp_next;

    // working registers
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]     m_data_reg;

    logic signed [OPND_W-1:0] diff, mul_a, mul_b;
    logic signed [TERM_W-1:0] term;
    logic signed [ASUM_W-1:0] acc_sum;
    logic signed [ACC_W-1:0]  acc_sat, lim_hi, lim_lo;
    logic                     acc_ovf, drive_ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            ien_reg    <= 1'b0;
            lim_hi_reg <= '0;
            lim_lo_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_PROP_GAIN:  kp_reg     <= cfg_data;
                REG_INTEG_GAIN: ki_reg     <= cfg_data;
                REG_DERIV_GAIN: kd_reg     <= cfg_data;
                REG_INTEG_EN:   ien_reg    <= cfg_data[0];
                REG_LIMIT_HIGH: lim_hi_reg <= cfg_data;
                REG_LIMIT_LOW:  lim_lo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg   <= s_tuser;
            err_reg  <= s_tdata[DATA_W-1:0];
            dt_reg   <= s_tdata[DATA_W +: DT_W];
            hold_reg <= s_tdata[DATA_W + DT_W];
        end
    end

    assign diff = first_reg ? '0 : (OPND_W'(err_reg) - OPND_W'(last_err_reg));
    // floor shift of a signed product is the upper slice
    assign term = prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        case (ctrl.uc.mul_a)
            MA_ERR:  mul_a = OPND_W'(err_reg);
            MA_INC:  mul_a = prod_reg[FRAC_W +: OPND_W];
            MA_DIFF: mul_a = diff;
            default: mul_a = OPND_W'(err_reg);
        endcase
        case (ctrl.uc.mul_b)
            MB_DT:   mul_b = signed'({(OPND_W-DT_W)'(0), dt_reg});
            MB_KI:   mul_b = OPND_W'(ki_reg);
            MB_KP:   mul_b = OPND_W'(kp_reg);
            MB_KD:   mul_b = OPND_W'(kd_reg);
            default: mul_b = OPND_W'(kp_reg);
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign acc_sum = ASUM_W'(acc_reg) + ASUM_W'(term);
    assign acc_ovf = !((&acc_sum[ASUM_W-1:ACC_W-1]) || !(|acc_sum[ASUM_W-1:ACC_W-1]));
    assign acc_sat = !acc_ovf ? acc_sum[ACC_W-1:0] :
                     acc_sum[ASUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} :
                                         {1'b0, {(ACC_W-1){1'b1}}};
    assign lim_hi  = ACC_W'(lim_hi_reg);
    assign lim_lo  = ACC_W'(lim_lo_reg);

    assign drive_ovf = !((&sum_reg[SUM_W-1:DATA_W-1]) || !(|sum_reg[SUM_W-1:DATA_W-1]));

    always_comb begin
        acc_next        = acc_reg;
        clamp_next      = clamp_reg;
        sum_next        = sum_reg;
        last_drive_next = last_drive_reg;
        case (ctrl.uc.acc_op)
            ACC_ADD:   acc_next = ien_reg ? acc_sat : '0;
            ACC_CLAMP: begin
                if (ien_reg && !hold_reg) begin
                    if (acc_reg > lim_hi) begin
                        acc_next   = lim_hi;
                        clamp_next = CLAMP_HIGH;
                    end else if (acc_reg < lim_lo) begin
                        acc_next   = lim_lo;
                        clamp_next = CLAMP_LOW;
                    end else begin
                        clamp_next = CLAMP_NONE;
                    end
                end
            end
            default: ;
        endcase
        case (ctrl.uc.sum_op)
            SUM_LOAD:     sum_next = SUM_W'(term);
            SUM_ADD_PROD: sum_next = sum_reg + SUM_W'(term);
            SUM_ADD_ACC:  sum_next = sum_reg + SUM_W'(acc_reg);
            default: ;
        endcase
        if (ctrl.uc.st_op == ST_COMMIT) begin
            last_drive_next = !drive_ovf ? sum_reg[DATA_W-1:0] :
                              sum_reg[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} :
                                                 {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fire) begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg   <= '0;
            last_drive_reg <= '0;
            acc_reg        <= '0;
            first_reg      <= 1'b0;
            clamp_reg      <= CLAMP_NONE;
        end else if (ctrl.fire) begin
            case (ctrl.uc.st_op)
                ST_CLEAR: begin
                    last_err_reg   <= '0;
                    last_drive_reg <= '0;
                    acc_reg        <= '0;
                    first_reg      <= 1'b1;
                    clamp_reg      <= CLAMP_NONE;
                end
                ST_COMMIT: begin
                    last_err_reg   <= err_reg;
                    last_drive_reg <= last_drive_next;
                    first_reg      <= 1'b0;
                end
                default: begin
                    acc_reg   <= acc_next;
                    clamp_reg <= clamp_next;
                end
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.fire && ctrl.uc.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fire && ctrl.uc.emit) begin
            m_data_reg <= {(OUT_TDATA_W-OUT_USED_W)'(0), clamp_reg, last_drive_reg};
        end
    end

    assign stat.clear_op = (op_reg == OP_CLEAR);
    assign stat.dt_zero  = (dt_reg == '0);
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/pidc_checker.sv =====
module pidc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pidc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pidc_pkg::*;

    // stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: ready drops right after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DATA_W +: CLAMP_W] == CLAMP_NONE ||
                      m_tdata[DATA_W +: CLAMP_W] == CLAMP_HIGH ||
                      m_tdata[DATA_W +: CLAMP_W] == CLAMP_LOW))
        else $error("bad clamp status");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not idle after reset");

endmodule

bind pid_controller_with_clamp pidc_checker u_pidc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
